// ----- src/necirtx_pkg.sv -----
package necirtx_pkg;

    // frame geometry
    localparam int unsigned FRAME_BITS = 32;
    localparam int unsigned BITS_W     = 6;

    // configuration port geometry
    localparam int unsigned REG_W = 20;
    localparam int unsigned IDX_W = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_GUARD_IDLE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEADER_MARK = 3'd1;
    localparam logic [IDX_W-1:0] REG_LEADER_SPC  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BIT_MARK    = 3'd3;
    localparam logic [IDX_W-1:0] REG_ONE_SPACE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_ZERO_SPACE  = 3'd5;
    localparam logic [IDX_W-1:0] REG_STOP_MARK   = 3'd6;

    // register reset values
    localparam logic [REG_W-1:0] RST_GUARD_IDLE  = 20'd500000;
    localparam logic [REG_W-1:0] RST_LEADER_MARK = 20'd9000;
    localparam logic [REG_W-1:0] RST_LEADER_SPC  = 20'd4400;
    localparam logic [REG_W-1:0] RST_BIT_MARK    = 20'd600;
    localparam logic [REG_W-1:0] RST_ONE_SPACE   = 20'd1600;
    localparam logic [REG_W-1:0] RST_ZERO_SPACE  = 20'd500;
    localparam logic [REG_W-1:0] RST_STOP_MARK   = 20'd600;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_GUARD  = 3'd1,
        PH_LMARK  = 3'd2,
        PH_LSPACE = 3'd3,
        PH_BMARK  = 3'd4,
        PH_BSPACE = 3'd5,
        PH_STOP   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [REG_W-1:0] guard_idle;
        logic [REG_W-1:0] leader_mark;
        logic [REG_W-1:0] leader_space;
        logic [REG_W-1:0] bit_mark;
        logic [REG_W-1:0] one_space;
        logic [REG_W-1:0] zero_space;
        logic [REG_W-1:0] stop_mark;
    } t_durations;

    typedef struct packed {
        logic led_on;
        logic busy_res;
        logic rejected;
        logic frame_done;
    } t_result;

endpackage

// ----- src/necirtx_regs.sv -----
module necirtx_regs
    import necirtx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data,
    output t_durations       o_dur
);

    t_durations r_dur;
    t_durations n_dur;

    always_comb begin
        n_dur = r_dur;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GUARD_IDLE:  n_dur.guard_idle   = i_cfg_data;
                REG_LEADER_MARK: n_dur.leader_mark  = i_cfg_data;
                REG_LEADER_SPC:  n_dur.leader_space = i_cfg_data;
                REG_BIT_MARK:    n_dur.bit_mark     = i_cfg_data;
                REG_ONE_SPACE:   n_dur.one_space    = i_cfg_data;
                REG_ZERO_SPACE:  n_dur.zero_space   = i_cfg_data;
                REG_STOP_MARK:   n_dur.stop_mark    = i_cfg_data;
                default:         n_dur              = r_dur; // unmapped index
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur.guard_idle   <= RST_GUARD_IDLE;
            r_dur.leader_mark  <= RST_LEADER_MARK;
            r_dur.leader_space <= RST_LEADER_SPC;
            r_dur.bit_mark     <= RST_BIT_MARK;
            r_dur.one_space    <= RST_ONE_SPACE;
            r_dur.zero_space   <= RST_ZERO_SPACE;
            r_dur.stop_mark    <= RST_STOP_MARK;
        end else begin
            r_dur <= n_dur;
        end
    end

    assign o_dur = r_dur;

endmodule

// ----- src/necirtx_skid.sv -----
module necirtx_skid
    import necirtx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    n_out_valid;
    logic    n_skid_valid;
    t_result n_out;
    t_result n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_out_ready) begin
            // output slot frees up: drain the skid entry first
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out        = i_data;
                n_out_valid  = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_data      = r_out;

endmodule

// ----- src/nec_ir_frame_transmitter_core.sv -----
// NEC infrared frame transmitter. Each input transaction is either one time tick (cmd = 0)
// or a start request (cmd = 1) carrying an address and a command byte; every transaction
// produces exactly one result transaction with led_on, busy_res, rejected and frame_done.
// A start while idle loads address, ~address, command, ~command (each byte LSB first) and
// begins the frame: LED-off guard, leader mark, leader space, 32 bits of mark plus long
// (one) or short (zero) space, then a stop mark; frame_done flags the last stop-mark tick.
// A start while a frame runs is answered with rejected = 1 and consumes no tick. All
// durations are configuration registers in ticks (0 behaves as 1) and apply from the next
// period that loads them. One transaction is accepted every clock cycle unless the skid
// entry is full; its result is registered into the output slot, or into the skid entry while
// the output stalls. The rate is set by the single phase/counter update per transaction; a
// two-entry output buffer lets one more transaction in after the output side stalls.
module nec_ir_frame_transmitter_core
    import necirtx_pkg::*;
#(
    parameter int unsigned TIMER_WIDTH = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cmd,
    input  logic [7:0]       i_address,
    input  logic [7:0]       i_command_code,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_led_on,
    output logic             o_busy_res,
    output logic             o_rejected,
    output logic             o_frame_done
);

    t_durations dur;
    t_result    res;
    t_result    out_res;
    logic       accept;

    // frame state
    t_phase                  r_phase;
    t_phase                  n_phase;
    logic [TIMER_WIDTH-1:0]  r_ticks;
    logic [TIMER_WIDTH-1:0]  n_ticks;
    logic [BITS_W-1:0]       r_bits;
    logic [BITS_W-1:0]       n_bits;
    logic [FRAME_BITS-1:0]   r_shift;
    logic [FRAME_BITS-1:0]   n_shift;
    logic [BITS_W-1:0]       bits_dec;
    logic                    is_mark;

    // register value to period length: fit to the timer, zero counts as one tick
    function automatic logic [TIMER_WIDTH-1:0] period_len(input logic [REG_W-1:0] r);
        logic [TIMER_WIDTH-1:0] d;
        d = TIMER_WIDTH'(r);
        return (d == '0) ? TIMER_WIDTH'(1) : d;
    endfunction

    necirtx_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_dur      (dur)
    );

    assign accept   = i_in_valid && o_in_ready;
    assign is_mark  = (r_phase == PH_LMARK) || (r_phase == PH_BMARK) || (r_phase == PH_STOP);
    assign bits_dec = r_bits - BITS_W'(1);

    // next state and result for the accepted transaction
    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        n_bits  = r_bits;
        n_shift = r_shift;
        res     = '0;
        if (accept) begin
            if (i_cmd) begin
                if (r_phase == PH_IDLE) begin
                    // load frame, guard period starts, no tick consumed
                    n_shift      = {~i_command_code, i_command_code, ~i_address, i_address};
                    n_bits       = BITS_W'(FRAME_BITS);
                    n_phase      = PH_GUARD;
                    n_ticks      = period_len(dur.guard_idle);
                    res.busy_res = 1'b1;
                end else begin
                    // start while busy: refused, frame untouched
                    res.rejected = 1'b1;
                    res.busy_res = 1'b1;
                    res.led_on   = is_mark;
                end
            end else if (r_phase != PH_IDLE) begin
                res.busy_res = 1'b1;
                res.led_on   = is_mark;
                if (r_ticks <= TIMER_WIDTH'(1)) begin
                    // period ends on this tick
                    unique case (r_phase)
                        PH_GUARD: begin
                            n_phase = PH_LMARK;
                            n_ticks = period_len(dur.leader_mark);
                        end
                        PH_LMARK: begin
                            n_phase = PH_LSPACE;
                            n_ticks = period_len(dur.leader_space);
                        end
                        PH_LSPACE: begin
                            n_phase = PH_BMARK;
                            n_ticks = period_len(dur.bit_mark);
                        end
                        PH_BMARK: begin
                            n_phase = PH_BSPACE;
                            n_ticks = r_shift[0] ? period_len(dur.one_space)
                                                 : period_len(dur.zero_space);
                        end
                        PH_BSPACE: begin
                            n_shift = r_shift >> 1;
                            n_bits  = bits_dec;
                            if (bits_dec == '0) begin
                                n_phase = PH_STOP;
                                n_ticks = period_len(dur.stop_mark);
                            end else begin
                                n_phase = PH_BMARK;
                                n_ticks = period_len(dur.bit_mark);
                            end
                        end
                        PH_STOP: begin
                            n_phase        = PH_IDLE;
                            n_ticks        = '0;
                            res.frame_done = 1'b1;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_ticks = '0;
                        end
                    endcase
                end else begin
                    n_ticks = r_ticks - TIMER_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ticks <= '0;
            r_bits  <= '0;
            r_shift <= '0;
        end else begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_bits  <= n_bits;
            r_shift <= n_shift;
        end
    end

    // result register plus skid entry
    necirtx_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (res),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (out_res)
    );

    assign o_led_on     = out_res.led_on;
    assign o_busy_res   = out_res.busy_res;
    assign o_rejected   = out_res.rejected;
    assign o_frame_done = out_res.frame_done;

endmodule

// ----- src/necirtx_checker.sv -----
module necirtx_checker
    import necirtx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic             o_led_on,
    input  logic             o_busy_res,
    input  logic             o_rejected,
    input  logic             o_frame_done
);

    // carrier only while a frame runs
    a_led_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_led_on |-> o_busy_res)
        else $error("led on outside a frame");

    // a refused start is only reported during a frame
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_busy_res && !o_frame_done)
        else $error("reject without busy");

    // frame ends on a tick of the stop mark
    a_done_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_led_on && o_busy_res && !o_rejected)
        else $error("frame done outside stop mark");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_led_on)
            && $stable(o_busy_res) && $stable(o_rejected) && $stable(o_frame_done))
        else $error("result changed while stalled");

endmodule

bind nec_ir_frame_transmitter_core necirtx_checker u_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import necirtx_pkg::*;

    localparam int unsigned TIMER_W     = 20;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned RAND_PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 52;
    localparam int unsigned DIR_ROWS    = 19;

    // index with no register behind it, writes there must change nothing
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [REG_W-1:0] DUR_MAX   = '1;

    // one directed transaction; want holds led, busy, rejected, done in that order
    typedef struct packed {
        logic       cmd;
        logic [7:0] addr;
        logic [7:0] code;
        logic       typed;
        t_result    want;
    } t_dir_row;

    // block ports, all inputs driven to known values from time zero
    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_we       = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx      = '0;
    logic [REG_W-1:0] i_cfg_data     = '0;
    logic             i_in_valid     = 1'b0;
    logic             o_in_ready;
    logic             i_cmd          = 1'b0;
    logic [7:0]       i_address      = '0;
    logic [7:0]       i_command_code = '0;
    logic             o_out_valid;
    logic             i_out_ready    = 1'b0;
    logic             o_led_on;
    logic             o_busy_res;
    logic             o_rejected;
    logic             o_frame_done;

    // shadow copy of the transmitter state
    t_phase               ir_phase;
    logic [TIMER_W-1:0]   period_ticks;
    logic [BITS_W-1:0]    bits_to_go;
    logic [FRAME_BITS-1:0] frame_bits;
    t_durations           cfg_now;

    // results still owed by the block, oldest first
    t_result     expected_q[$];

    // handshake bookkeeping shared by driver and monitor
    logic        took_item  = 1'b0;
    logic        fixed_on   = 1'b0;
    t_result     fixed_res  = '0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned cycle_count   = 0;

    // start payloads alternate with their inverse so every address and command bit toggles
    logic        flip_next;
    logic [7:0]  last_addr;
    logic [7:0]  last_code;

    t_dir_row    dir_rows [DIR_ROWS];

    always #5 i_clk = ~i_clk;

    nec_ir_frame_transmitter_core #(
        .TIMER_WIDTH(TIMER_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_address      (i_address),
        .i_command_code (i_command_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_led_on       (o_led_on),
        .o_busy_res     (o_busy_res),
        .o_rejected     (o_rejected),
        .o_frame_done   (o_frame_done)
    );

    // a programmed zero still lasts one tick
    function automatic logic [TIMER_W-1:0] period_of(input logic [REG_W-1:0] v);
        logic [TIMER_W-1:0] d;
        d = TIMER_W'(v);
        return (d == '0) ? TIMER_W'(1) : d;
    endfunction

    function automatic void enter_period(input t_phase p, input logic [REG_W-1:0] v);
        ir_phase     = p;
        period_ticks = period_of(v);
    endfunction

    // expected result of one transaction, advancing the shadow state
    function automatic t_result predict_ir(input logic start, input logic [7:0] addr,
                                            input logic [7:0] code);
        t_result r;
        r = '0;
        // outputs reflect the period in force when the transaction arrives
        if (ir_phase != PH_IDLE) begin
            r.busy_res = 1'b1;
            r.led_on   = (ir_phase == PH_LMARK) || (ir_phase == PH_BMARK) ||
                         (ir_phase == PH_STOP);
        end
        if (start) begin
            if (ir_phase == PH_IDLE) begin
                // bytes go out lsb first: address, ~address, command, ~command
                frame_bits = {~code, code, ~addr, addr};
                bits_to_go = BITS_W'(FRAME_BITS);
                enter_period(PH_GUARD, cfg_now.guard_idle);
                r.busy_res = 1'b1;
            end else begin
                // busy: refused, no tick consumed
                r.rejected = 1'b1;
            end
        end else if (ir_phase != PH_IDLE) begin
            if (period_ticks <= 1) begin
                case (ir_phase)
                    PH_GUARD:  enter_period(PH_LMARK, cfg_now.leader_mark);
                    PH_LMARK:  enter_period(PH_LSPACE, cfg_now.leader_space);
                    PH_LSPACE: enter_period(PH_BMARK, cfg_now.bit_mark);
                    PH_BMARK:  enter_period(PH_BSPACE, frame_bits[0] ? cfg_now.one_space
                                                                   : cfg_now.zero_space);
                    PH_BSPACE: begin
                        frame_bits = frame_bits >> 1;
                        bits_to_go = bits_to_go - 1'b1;
                        if (bits_to_go == '0) begin
                            enter_period(PH_STOP, cfg_now.stop_mark);
                        end else begin
                            enter_period(PH_BMARK, cfg_now.bit_mark);
                        end
                    end
                    PH_STOP: begin
                        ir_phase     = PH_IDLE;
                        period_ticks = '0;
                        r.frame_done = 1'b1;
                    end
                    default: begin
                        ir_phase     = PH_IDLE;
                        period_ticks = '0;
                    end
                endcase
            end else begin
                period_ticks = period_ticks - 1'b1;
            end
        end
        return r;
    endfunction

    // mostly short periods, now and then a zero
    function automatic logic [REG_W-1:0] pick_duration(input int unsigned hi);
        if ($urandom_range(99) < 15) return '0;
        return REG_W'($urandom_range(hi, 1));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // one register write per cycle; the enable is left high for back-to-back writes
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            REG_GUARD_IDLE:  cfg_now.guard_idle   = val;
            REG_LEADER_MARK: cfg_now.leader_mark  = val;
            REG_LEADER_SPC:  cfg_now.leader_space = val;
            REG_BIT_MARK:    cfg_now.bit_mark     = val;
            REG_ONE_SPACE:   cfg_now.one_space    = val;
            REG_ZERO_SPACE:  cfg_now.zero_space   = val;
            REG_STOP_MARK:   cfg_now.stop_mark    = val;
            default: ;
        endcase
    endtask

    // full register set; max_first writes all ones first, overwritten before any tick
    task automatic program_durations(input t_durations d, input logic max_first);
        if (max_first) begin
            for (int r = REG_GUARD_IDLE; r <= REG_STOP_MARK; r++) begin
                write_reg(IDX_W'(r), DUR_MAX);
            end
        end
        write_reg(REG_GUARD_IDLE,  d.guard_idle);
        write_reg(REG_LEADER_MARK, d.leader_mark);
        write_reg(REG_LEADER_SPC,  d.leader_space);
        write_reg(REG_BIT_MARK,    d.bit_mark);
        write_reg(REG_ONE_SPACE,   d.one_space);
        write_reg(REG_ZERO_SPACE,  d.zero_space);
        write_reg(REG_STOP_MARK,   d.stop_mark);
        write_reg(REG_SPARE, max_first ? DUR_MAX : REG_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // drop valid and wait until every owed result is back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // present one transaction and hold it until accepted; valid stays high on return
    task automatic send_item(input logic cmd, input logic [7:0] addr, input logic [7:0] code,
                             input logic typed, input t_result want);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_address      <= addr;
        i_command_code <= code;
        fixed_on       <= typed;
        fixed_res      <= want;
        do @(negedge i_clk); while (!took_item);
    endtask

    // result side back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // monitor: check results against the oldest expectation, then record new transactions
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        cycle_count++;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_led_on, o_busy_res, o_rejected, o_frame_done};
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end else begin
                want = expected_q.pop_front();
                if (got.led_on !== want.led_on)
                    report_mismatch($sformatf("result %0d led_on %b, expected %b",
                                              results_seen, got.led_on, want.led_on));
                if (got.busy_res !== want.busy_res)
                    report_mismatch($sformatf("result %0d busy_res %b, expected %b",
                                              results_seen, got.busy_res, want.busy_res));
                if (got.rejected !== want.rejected)
                    report_mismatch($sformatf("result %0d rejected %b, expected %b",
                                              results_seen, got.rejected, want.rejected));
                if (got.frame_done !== want.frame_done)
                    report_mismatch($sformatf("result %0d frame_done %b, expected %b",
                                              results_seen, got.frame_done,
                                              want.frame_done));
            end
        end
        took_item = i_rst_n && i_in_valid && o_in_ready;
        if (took_item) begin
            // predictor always runs so its state stays in step with typed rows
            want = predict_ir(i_cmd, i_address, i_command_code);
            if (fixed_on) want = fixed_res;
            expected_q.push_back(want);
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_durations d;
        logic [7:0] addr;
        logic [7:0] code;
        logic       start;

        ir_phase     = PH_IDLE;
        period_ticks = '0;
        bits_to_go   = '0;
        frame_bits   = '0;
        cfg_now      = {RST_GUARD_IDLE, RST_LEADER_MARK, RST_LEADER_SPC, RST_BIT_MARK,
                        RST_ONE_SPACE, RST_ZERO_SPACE, RST_STOP_MARK};

        // directed frame with tiny periods: guard 0, leader 1/2, mark 1, one 2, zero 0, stop 1
        dir_rows = '{
            {1'b0, 8'hFF, 8'hFF, 1'b1, 4'b0000},  // tick while idle, ignored payload
            {1'b1, 8'h00, 8'hFF, 1'b1, 4'b0100},  // start while idle, byte extremes
            {1'b1, 8'hFF, 8'h00, 1'b1, 4'b0110},  // start refused during guard
            {1'b0, 8'h00, 8'h00, 1'b1, 4'b0100},  // zero-length guard takes one tick
            {1'b1, 8'h5A, 8'hA5, 1'b1, 4'b1110},  // start refused during leader mark
            {1'b0, 8'hFF, 8'hFF, 1'b1, 4'b1100},  // leader mark ends
            {1'b0, 8'h00, 8'h00, 1'b1, 4'b0100},  // leader space
            {1'b0, 8'h00, 8'h00, 1'b1, 4'b0100},  // leader space ends
            {1'b0, 8'h00, 8'h00, 1'b1, 4'b1100},  // first bit mark
            {1'b0, 8'h00, 8'h00, 1'b1, 4'b0100},  // zero-length short space
            {1'b1, 8'h33, 8'hCC, 1'b1, 4'b1110},  // start refused during bit mark
            {1'b0, 8'h80, 8'h01, 1'b0, 4'b0000},
            {1'b0, 8'h01, 8'h80, 1'b0, 4'b0000},
            {1'b0, 8'hAA, 8'h55, 1'b0, 4'b0000},
            {1'b0, 8'h55, 8'hAA, 1'b0, 4'b0000},
            {1'b1, 8'h0F, 8'hF0, 1'b0, 4'b0000},
            {1'b0, 8'hF0, 8'h0F, 1'b0, 4'b0000},
            {1'b0, 8'h00, 8'h00, 1'b0, 4'b0000},
            {1'b0, 8'hFF, 8'hFF, 1'b0, 4'b0000}
        };

        // reset held from time zero, released once
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // every register written, all ones first, then the directed durations
        d = {20'd0, 20'd1, 20'd2, 20'd1, 20'd2, 20'd0, 20'd1};
        program_durations(d, 1'b1);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_item(dir_rows[r].cmd, dir_rows[r].addr, dir_rows[r].code,
                      dir_rows[r].typed, dir_rows[r].want);
        end

        // rewrite periods mid-frame: only periods loaded afterwards see the new values
        settle();
        d            = cfg_now;
        d.bit_mark   = 20'd2;
        d.one_space  = 20'd3;
        d.zero_space = 20'd1;
        d.stop_mark  = 20'd0;
        program_durations(d, 1'b0);
        while (ir_phase != PH_IDLE) begin
            send_item(1'b0, 8'($urandom), 8'($urandom), 1'b0, '0);
        end

        flip_next = 1'b1;
        last_addr = 8'h00;
        last_code = 8'hFF;

        // random phases, each with its own idling pattern and register set
        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 54;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 54;
                end
                default: begin
                    send_idle_pct = 10;
                    stall_pct     = 10;
                end
            endcase
            // mostly short frames; sometimes the framing periods get long
            start = ($urandom_range(4) == 0);
            d.guard_idle   = pick_duration(start ? 150 : 4);
            d.leader_mark  = pick_duration(start ? 150 : 4);
            d.leader_space = pick_duration(start ? 150 : 4);
            d.bit_mark     = pick_duration(2);
            d.one_space    = pick_duration(3);
            d.zero_space   = pick_duration(2);
            d.stop_mark    = pick_duration(start ? 150 : 4);
            program_durations(d, $urandom_range(3) == 0);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                addr = 8'($urandom);
                code = 8'($urandom);
                // idle: nearly always start a frame; busy: mostly ticks, a few refused starts
                if (ir_phase == PH_IDLE) start = ($urandom_range(99) < 80);
                else start = ($urandom_range(99) < 4);
                if (start && ir_phase == PH_IDLE) begin
                    if (flip_next) begin
                        addr = ~last_addr;
                        code = ~last_code;
                    end
                    flip_next = ~flip_next;
                    last_addr = addr;
                    last_code = code;
                end
                // occasional hold-off until the block has handed everything back
                if ($urandom_range(63) == 0) settle();
                send_item(start, addr, code, 1'b0, '0);
            end
        end

        settle();
        repeat (10) @(negedge i_clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/necirtx_pkg.sv
src/necirtx_regs.sv
src/necirtx_skid.sv
src/nec_ir_frame_transmitter_core.sv
src/necirtx_checker.sv
test/testbench.sv
